@@ rtl/core/slp_pkg.sv @@
// Shared types and constants of the sound register log parser.
`timescale 1ns / 1ps

package slp_pkg;

  // Command bytes of the dump stream
  localparam logic [7:0] CMD_BANK0 = 8'h00;
  localparam logic [7:0] CMD_BANK1 = 8'h01;
  localparam logic [7:0] CMD_SYNC  = 8'hff;
  localparam logic [7:0] CMD_LONG  = 8'hfe;
  localparam logic [7:0] CMD_END   = 8'hfd;

  // Timer control register and its data mask
  localparam logic [7:0] TIMER_REG  = 8'h27;
  localparam logic [7:0] TIMER_MASK = 8'hf3;

  // Length groups: seven payload bits, top bit flags another group
  localparam logic [7:0] GROUP_MASK   = 8'h7f;
  localparam logic [7:0] GROUP_CONT   = 8'h80;
  localparam logic [2:0] GROUP_LIMIT  = 3'd5;
  localparam int         WAIT_W       = 33;
  localparam int         ACCUM_W      = 32;
  localparam logic [WAIT_W-1:0] WAIT_BIAS = 33'd2;
  localparam logic [WAIT_W-1:0] WAIT_ONE  = 33'd1;

  // Reset value of the timer mask enable
  localparam logic TIMER_MASK_EN_RST = 1'b1;

  typedef enum logic [2:0] {
    KIND_WR0  = 3'd0,
    KIND_WR1  = 3'd1,
    KIND_WAIT = 3'd2,
    KIND_END  = 3'd3,
    KIND_BAD  = 3'd4
  } slp_kind_e;

  typedef enum logic [2:0] {
    PH_CMD  = 3'd0,
    PH_ADDR = 3'd1,
    PH_DATA = 3'd2,
    PH_LEN  = 3'd3,
    PH_HALT = 3'd4
  } slp_phase_e;

  typedef struct packed {
    slp_phase_e         phase;
    logic               bank;
    logic [7:0]         addr;
    logic [ACCUM_W-1:0] accum;
    logic [2:0]         groups;
  } slp_state_t;

  typedef struct packed {
    slp_kind_e         kind;
    logic [7:0]        reg_addr;
    logic [7:0]        reg_data;
    logic [WAIT_W-1:0] wait_syncs;
  } slp_result_t;

endpackage

@@ rtl/core/slp_byte_if.sv @@
// Byte stream channel into the parser.
`timescale 1ns / 1ps

interface slp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/slp_result_if.sv @@
// Result channel out of the parser.
`timescale 1ns / 1ps

interface slp_result_if;
  logic                          valid;
  logic                          ready;
  slp_pkg::slp_kind_e            kind;
  logic [7:0]                    reg_addr;
  logic [7:0]                    reg_data;
  logic [slp_pkg::WAIT_W-1:0]    wait_syncs;

  modport source (output valid, output kind, output reg_addr, output reg_data,
                  output wait_syncs, input ready);
  modport sink   (input valid, input kind, input reg_addr, input reg_data,
                  input wait_syncs, output ready);
endinterface

@@ rtl/core/slp_decode.sv @@
// Per-byte decode: next parser state and the result a byte gives.
`timescale 1ns / 1ps

module slp_decode (
  input  slp_pkg::slp_state_t  cur_i,
  input  logic [7:0]           byte_i,
  input  logic                 mask_en_i,
  output slp_pkg::slp_state_t  nxt_o,
  output logic                 emit_o,
  output slp_pkg::slp_result_t res_o
);
  import slp_pkg::*;

  logic [7:0]         group;
  logic [ACCUM_W-1:0] accum_new;
  logic [7:0]         data_mask;

  // Place the current length group at its bit position
  always_comb begin
    group = byte_i & GROUP_MASK;
    unique case (cur_i.groups)
      3'd0:    accum_new = cur_i.accum | {25'd0, group[6:0]};
      3'd1:    accum_new = cur_i.accum | {18'd0, group[6:0], 7'd0};
      3'd2:    accum_new = cur_i.accum | {11'd0, group[6:0], 14'd0};
      3'd3:    accum_new = cur_i.accum | {4'd0, group[6:0], 21'd0};
      3'd4:    accum_new = cur_i.accum | {group[3:0], 28'd0};
      default: accum_new = cur_i.accum;
    endcase
  end

  // Mask timer control data when enabled
  assign data_mask = (cur_i.addr == TIMER_REG && mask_en_i) ? TIMER_MASK : 8'hff;

  // Advance the phase and form the result
  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    res_o  = '{kind: KIND_WR0, reg_addr: 8'd0, reg_data: 8'd0, wait_syncs: '0};
    unique case (cur_i.phase)
      PH_CMD: begin
        priority if (byte_i == CMD_BANK0 || byte_i == CMD_BANK1) begin
          nxt_o.bank  = byte_i[0];
          nxt_o.phase = PH_ADDR;
        end else if (byte_i == CMD_SYNC) begin
          emit_o           = 1'b1;
          res_o.kind       = KIND_WAIT;
          res_o.wait_syncs = WAIT_ONE;
        end else if (byte_i == CMD_LONG) begin
          nxt_o.accum  = '0;
          nxt_o.groups = 3'd0;
          nxt_o.phase  = PH_LEN;
        end else if (byte_i == CMD_END) begin
          nxt_o.phase = PH_HALT;
          emit_o      = 1'b1;
          res_o.kind  = KIND_END;
        end else begin
          nxt_o.phase    = PH_HALT;
          emit_o         = 1'b1;
          res_o.kind     = KIND_BAD;
          res_o.reg_data = byte_i;
        end
      end
      PH_ADDR: begin
        nxt_o.addr  = byte_i;
        nxt_o.phase = PH_DATA;
      end
      PH_DATA: begin
        nxt_o.phase    = PH_CMD;
        emit_o         = 1'b1;
        res_o.kind     = cur_i.bank ? KIND_WR1 : KIND_WR0;
        res_o.reg_addr = cur_i.addr;
        res_o.reg_data = byte_i & data_mask;
      end
      PH_LEN: begin
        if (cur_i.groups < GROUP_LIMIT) begin
          nxt_o.groups = cur_i.groups + 3'd1;
        end
        nxt_o.accum = accum_new;
        if ((byte_i & GROUP_CONT) == 8'd0) begin
          nxt_o.phase      = PH_CMD;
          emit_o           = 1'b1;
          res_o.kind       = KIND_WAIT;
          res_o.wait_syncs = {1'b0, accum_new} + WAIT_BIAS;
        end
      end
      PH_HALT: begin
        nxt_o = cur_i;
      end
      default: begin
        nxt_o.phase = PH_HALT;
      end
    endcase
  end

endmodule

@@ rtl/core/sound_register_log_parser_core.sv @@
// A completed result is registered in the output stage when its last byte is transferred.
// Throughput: one byte per cycle; the decode is a single pass into the result register.
// A two-entry output stage (result register plus skid register) keeps input open
// while one result waits; input stalls only when both entries are full.
// Reset (asynchronous, active low) returns the parser to command phase, empties the
// output stage and sets the timer mask enable.
`timescale 1ns / 1ps

module sound_register_log_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  slp_byte_if.sink            in_bus,
  slp_result_if.source        out_bus,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import slp_pkg::*;

  slp_state_t  state_q, state_d;
  slp_result_t dec_res;
  logic        dec_emit;
  logic        mask_en_q;

  slp_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_xfer, out_xfer, res_load;

  assign in_bus.ready = !skid_valid_q;
  assign in_xfer      = in_bus.valid && in_bus.ready;
  assign out_xfer     = out_valid_q && out_bus.ready;
  assign res_load     = in_xfer && dec_emit;

  slp_decode u_decode (
    .cur_i     (state_q),
    .byte_i    (in_bus.data_byte),
    .mask_en_i (mask_en_q),
    .nxt_o     (state_d),
    .emit_o    (dec_emit),
    .res_o     (dec_res)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_en_q <= TIMER_MASK_EN_RST;
    end else if (cfg_we_i) begin
      mask_en_q <= cfg_wdata_i;
    end
  end

  // Parser state advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_CMD, bank: 1'b0, addr: 8'd0, accum: '0, groups: 3'd0};
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Output stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_xfer) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_load && out_valid_q && !out_bus.ready) begin
        skid_valid_q <= 1'b1;
      end
      if (res_load || skid_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (res_load) begin
      if (!out_valid_q || out_bus.ready) begin
        out_q <= dec_res;
      end else begin
        skid_q <= dec_res;
      end
    end
  end

  assign out_bus.valid      = out_valid_q;
  assign out_bus.kind       = out_q.kind;
  assign out_bus.reg_addr   = out_q.reg_addr;
  assign out_bus.reg_data   = out_q.reg_data;
  assign out_bus.wait_syncs = out_q.wait_syncs;

`ifndef NO_ASSERTIONS
  // Skid entry is only ever occupied behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // A halted parser produces nothing
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_HALT) |-> !dec_emit)
    else $error("result decoded while halted");

  // Length group count stays within five
  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.groups <= GROUP_LIMIT)
    else $error("length group count out of range");

  // A result arriving at a stalled output lands in the skid entry
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && out_valid_q && !out_bus.ready) |=> skid_valid_q)
    else $error("result lost at stalled output");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench of the sound register log parser core.
`timescale 1ns / 1ps

module testbench;
  import slp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned REPORT_CAP  = 100;
  localparam int unsigned PHASE_BYTES = 120;
  localparam int unsigned TAIL_BYTES  = 100;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  slp_byte_if   byte_bus ();
  slp_result_if result_bus ();

  sound_register_log_parser_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_bus     (byte_bus),
    .out_bus    (result_bus),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Parser state as the block should hold it
  slp_phase_e         prs_phase;
  logic               prs_bank;
  logic [7:0]         prs_addr;
  logic [ACCUM_W-1:0] prs_accum;
  logic [2:0]         prs_groups;
  logic               prs_mask_en;

  slp_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned hold_left;
  int unsigned stall_left;
  bit          quiet;
  bit          hold_req;

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drive result ready: long hold-offs on request, short random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Compare every result transfer with the oldest pending prediction
  always @(posedge clk_i) begin
    slp_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing pending",
                                  result_bus.kind));
      end else begin
        want = pending_results.pop_front();
        if (result_bus.kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", result_bus.kind, want.kind));
        if (result_bus.reg_addr !== want.reg_addr)
          report_mismatch($sformatf("reg_addr got %h want %h",
                                    result_bus.reg_addr, want.reg_addr));
        if (result_bus.reg_data !== want.reg_data)
          report_mismatch($sformatf("reg_data got %h want %h",
                                    result_bus.reg_data, want.reg_data));
        if (result_bus.wait_syncs !== want.wait_syncs)
          report_mismatch($sformatf("wait_syncs got %h want %h",
                                    result_bus.wait_syncs, want.wait_syncs));
      end
    end
  end

  function automatic void reset_parser_state();
    prs_phase   = PH_CMD;
    prs_bank    = 1'b0;
    prs_addr    = '0;
    prs_accum   = '0;
    prs_groups  = '0;
    prs_mask_en = TIMER_MASK_EN_RST;
  endfunction

  // Advance the parser state by one byte; return 1 when the byte completes a result
  function automatic bit parse_byte(input logic [7:0] b, output slp_result_t res);
    logic [ACCUM_W-1:0] grp;
    res        = '0;
    parse_byte = 1'b0;
    case (prs_phase)
      PH_CMD: begin
        if (b == CMD_BANK0 || b == CMD_BANK1) begin
          prs_bank  = b[0];
          prs_phase = PH_ADDR;
        end else if (b == CMD_SYNC) begin
          res.kind       = KIND_WAIT;
          res.wait_syncs = WAIT_ONE;
          parse_byte     = 1'b1;
        end else if (b == CMD_LONG) begin
          prs_accum  = '0;
          prs_groups = '0;
          prs_phase  = PH_LEN;
        end else if (b == CMD_END) begin
          prs_phase  = PH_HALT;
          res.kind   = KIND_END;
          parse_byte = 1'b1;
        end else begin
          prs_phase    = PH_HALT;
          res.kind     = KIND_BAD;
          res.reg_data = b;
          parse_byte   = 1'b1;
        end
      end
      PH_ADDR: begin
        prs_addr  = b;
        prs_phase = PH_DATA;
      end
      PH_DATA: begin
        res.kind     = prs_bank ? KIND_WR1 : KIND_WR0;
        res.reg_addr = prs_addr;
        res.reg_data = (prs_addr == TIMER_REG && prs_mask_en) ? (b & TIMER_MASK) : b;
        prs_phase    = PH_CMD;
        parse_byte   = 1'b1;
      end
      PH_LEN: begin
        // Groups past the limit add nothing; the fifth one is cut at 32 bits
        if (prs_groups < GROUP_LIMIT) begin
          grp        = {24'd0, b & GROUP_MASK};
          prs_accum  = prs_accum | (grp << (7 * prs_groups));
          prs_groups = prs_groups + 3'd1;
        end
        if ((b & GROUP_CONT) == '0) begin
          res.kind       = KIND_WAIT;
          res.wait_syncs = {1'b0, prs_accum} + WAIT_BIAS;
          prs_phase      = PH_CMD;
          parse_byte     = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one byte, with an occasional idle burst first, and predict at its transfer
  task automatic push_byte(input logic [7:0] b);
    slp_result_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    bytes_sent++;
    if (parse_byte(b, res)) pending_results.push_back(res);
  endtask

  // Hold input and wait until every predicted result has been seen
  task automatic settle_results();
    byte_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timer_mask(input logic en);
    settle_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk_i);
    prs_mask_en = en;
    cfg_we <= 1'b0;
  endtask

  task automatic send_write(input logic bank, input logic [7:0] addr, input logic [7:0] data);
    push_byte(bank ? CMD_BANK1 : CMD_BANK0);
    push_byte(addr);
    push_byte(data);
  endtask

  task automatic send_long_wait(input int unsigned n_groups);
    push_byte(CMD_LONG);
    for (int unsigned i = 0; i < n_groups; i++)
      push_byte({i != n_groups - 1, 7'($urandom_range(0, 127))});
  endtask

  // Pick one well-formed command with random content
  task automatic send_random_command();
    int unsigned pick;
    logic [7:0]  addr;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      addr = ($urandom_range(0, 4) == 0) ? TIMER_REG : 8'($urandom_range(0, 255));
      send_write(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      push_byte(CMD_SYNC);
    end else if (pick < 85) begin
      send_long_wait($urandom_range(1, 2));
    end else begin
      send_long_wait($urandom_range(3, 8));
    end
  endtask

  task automatic test_directed_writes();
    send_write(1'b0, 8'h00, 8'hff);
    send_write(1'b1, 8'hff, 8'h00);
    send_write(1'b0, TIMER_REG, 8'hff);
  endtask

  task automatic test_sync_and_long_waits();
    push_byte(CMD_SYNC);
    // Shortest length: one zero group
    push_byte(CMD_LONG);
    push_byte(8'h00);
    // Five full groups: the top one is cut and the sum needs bit 32
    push_byte(CMD_LONG);
    repeat (4) push_byte(8'hff);
    push_byte(8'h7f);
    // Groups past the fifth still chain but add nothing
    push_byte(CMD_LONG);
    repeat (4) push_byte(8'h80);
    push_byte(8'hff);
    push_byte(8'h81);
    push_byte(8'h01);
  endtask

  task automatic test_timer_mask_setting();
    write_timer_mask(1'b0);
    send_write(1'b0, TIMER_REG, 8'hff);
    send_write(1'b1, TIMER_REG, 8'h0c);
    write_timer_mask(1'b1);
    send_write(1'b1, TIMER_REG, 8'hff);
    send_write(1'b0, 8'h28, 8'hff);
  endtask

  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_command();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 4; ph++) begin
      write_timer_mask(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      test_random_stream(PHASE_BYTES);
    end
  endtask

  // Stall the result side long enough for the output stage to fill and block input
  task automatic test_receiver_hold_off();
    settle_results();
    hold_req = 1'b1;
    test_random_stream(40);
    settle_results();
  endtask

  // Stop the stream with an end mark or a bad command, then check it stays halted
  task automatic test_halt();
    if ($urandom_range(0, 1) == 0) push_byte(CMD_END);
    else push_byte(8'($urandom_range(2, 252)));
    repeat (6) push_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= 1'b0;
    byte_bus.valid       <= 1'b0;
    byte_bus.data_byte   <= '0;
    mismatches  = 0;
    cycle_count = 0;
    bytes_sent  = 0;
    hold_left   = 0;
    stall_left  = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    reset_parser_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_writes();
    test_sync_and_long_waits();
    test_timer_mask_setting();
    test_random_settings();
    test_receiver_hold_off();
    quiet = 1'b1;
    test_random_stream(TAIL_BYTES);
    test_halt();

    settle_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
